>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define PTA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define PTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pta_pkg.sv
`timescale 1ns / 1ps

package pta_pkg;

  localparam int ADDR_W     = 32;
  localparam int OP_W       = 3;
  localparam int CNT_IN_W   = 17;
  localparam int TYPE_W     = 4;
  localparam int STAT_W     = 2;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int PIN_W      = 17;

  localparam int PAGE_COUNT_DEF = 65536;

  localparam logic [ADDR_W-1:0] TOP_RESET = 32'h1000_0000;
  localparam logic [PIN_W-1:0]  PIN_RESET = 17'h1_0000;

  localparam logic [OP_W-1:0] OP_ALLOC_ANY   = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_BELOW = 3'd1;
  localparam logic [OP_W-1:0] OP_ALLOC_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE        = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD        = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_RES    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  localparam logic [TYPE_W-1:0] TYPE_FREE     = 4'd7;
  localparam logic [TYPE_W-1:0] TYPE_RSVD_MIN = 4'd14;

  // register indexes on the config bus (word address bit)
  localparam logic REG_TOP = 1'b0;
  localparam logic REG_PIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } pta_state_t;

  typedef enum logic [1:0] {
    PLAN_DONE,
    PLAN_SCAN,
    PLAN_WRITE
  } pta_plan_t;

  typedef struct packed {
    logic accept;
    logic plan_apply;
    logic scan_step;
    logic write_step;
    logic out_load;
  } pta_cmd_t;

  typedef struct packed {
    pta_plan_t plan;
    logic      scan_found;
    logic      scan_fail;
    logic      write_busy;
    logic      out_full;
  } pta_stat_t;

endpackage

>>> rtl/page_type_map_allocator.sv
// One request at a time: accept, check, then for allocations a map scan at one entry
// per cycle through the RAM read port, a retype of one entry per cycle through the
// write port for a found run and for free and load, and a load into the output
// register once the output is free. Invalid requests skip the scan and the write.
// Reset (rst_n low, synchronous) clears control and loads the register defaults; the
// page map is not cleared and holds unknown types until loaded.
`timescale 1ns / 1ps

module page_type_map_allocator #(
  parameter int PAGE_COUNT = pta_pkg::PAGE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pta_pkg::OP_W-1:0]      in_opcode,
  input  logic [pta_pkg::ADDR_W-1:0]    in_address,
  input  logic [pta_pkg::CNT_IN_W-1:0]  in_page_count,
  input  logic [pta_pkg::TYPE_W-1:0]    in_mem_type,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pta_pkg::STAT_W-1:0]    out_status,
  output logic [pta_pkg::ADDR_W-1:0]    out_base_address,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import pta_pkg::*;

  pta_cmd_t                          cmd;
  pta_stat_t                         stat;
  logic [ADDR_W-1:0]                 top_of_memory;
  logic [$clog2(PAGE_COUNT+1)-1:0]   scan_len;

  pta_regs #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .top_of_memory(top_of_memory),
    .scan_len     (scan_len)
  );

  pta_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  pta_datapath #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_opcode),
    .in_address      (in_address),
    .in_page_count   (in_page_count),
    .in_mem_type     (in_mem_type),
    .top_of_memory   (top_of_memory),
    .scan_len        (scan_len),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_base_address(out_base_address)
  );

endmodule

>>> rtl/pta_ram.sv
`timescale 1ns / 1ps

module pta_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/pta_regs.sv
`timescale 1ns / 1ps

module pta_regs #(
  parameter int PAGE_COUNT = pta_pkg::PAGE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [pta_pkg::ADDR_W-1:0]        top_of_memory,
  output logic [$clog2(PAGE_COUNT+1)-1:0]   scan_len
);

  import pta_pkg::*;

  localparam int CNT_W = $clog2(PAGE_COUNT + 1);
  localparam int LW    = (CNT_W > PIN_W) ? CNT_W : PIN_W;

  logic [ADDR_W-1:0] top_r;
  logic [PIN_W-1:0]  pin_r;
  logic              wr_hit;
  logic [LW-1:0]     pin_x;
  logic [LW-1:0]     pmax_x;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= TOP_RESET;
      pin_r <= PIN_RESET;
    end else if (wr_hit) begin
      if (paddr[2] == REG_PIN) begin
        pin_r <= pwdata[PIN_W-1:0];
      end else begin
        top_r <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_PIN) ? {{(32-PIN_W){1'b0}}, pin_r} : top_r;

  // entries covered by a scan: the smaller of the register and the map size
  assign pin_x    = LW'(pin_r);
  assign pmax_x   = LW'(PAGE_COUNT);
  assign scan_len = (pin_x < pmax_x) ? CNT_W'(pin_x) : CNT_W'(pmax_x);

  assign top_of_memory = top_r;

endmodule

>>> rtl/pta_ctrl.sv
`timescale 1ns / 1ps

module pta_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pta_pkg::pta_stat_t stat,
  output pta_pkg::pta_cmd_t  cmd
);

  import pta_pkg::*;

  pta_state_t state_r;
  pta_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.plan_apply = 1'b1;
        case (stat.plan)
          PLAN_SCAN:  state_nxt = ST_SCAN;
          PLAN_WRITE: state_nxt = ST_WRITE;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_found) begin
          state_nxt = ST_WRITE;
        end else if (stat.scan_fail) begin
          state_nxt = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd.write_step = 1'b1;
        if (!stat.write_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/pta_datapath.sv
`timescale 1ns / 1ps

module pta_datapath #(
  parameter int PAGE_COUNT = pta_pkg::PAGE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pta_pkg::pta_cmd_t                 cmd,
  output pta_pkg::pta_stat_t                stat,
  input  logic [pta_pkg::OP_W-1:0]          in_opcode,
  input  logic [pta_pkg::ADDR_W-1:0]        in_address,
  input  logic [pta_pkg::CNT_IN_W-1:0]      in_page_count,
  input  logic [pta_pkg::TYPE_W-1:0]        in_mem_type,
  input  logic [pta_pkg::ADDR_W-1:0]        top_of_memory,
  input  logic [$clog2(PAGE_COUNT+1)-1:0]   scan_len,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [pta_pkg::STAT_W-1:0]        out_status,
  output logic [pta_pkg::ADDR_W-1:0]        out_base_address
);

  import pta_pkg::*;

  localparam int CNT_W  = $clog2(PAGE_COUNT + 1);
  localparam int PIDX_W = $clog2(PAGE_COUNT);
  localparam int SW     = (CNT_W > PAGE_W + 1) ? CNT_W : PAGE_W + 1;

  // request word
  logic [OP_W-1:0]     op_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [CNT_IN_W-1:0] cnt_r;
  logic [TYPE_W-1:0]   mt_r;

  // scan and write state
  logic [SW-1:0]       iss_r;
  logic [SW-1:0]       send_r;
  logic [SW-1:0]       chk_r;
  logic                vld_r;
  logic                ff_r;
  logic                lim_r;
  logic [CNT_IN_W-1:0] run_r;
  logic [SW-1:0]       start_r;
  logic [SW-1:0]       wp_r;
  logic [SW-1:0]       wend_r;
  logic [TYPE_W-1:0]   wtype_r;

  logic [STAT_W-1:0]   res_status_r;
  logic [ADDR_W-1:0]   res_base_r;
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [ADDR_W-1:0]   out_base_r;

  // check stage
  logic [PAGE_W-1:0]   page;
  logic [SW-1:0]       page_x;
  logic [SW-1:0]       n_x;
  logic [SW-1:0]       cnt_x;
  logic [SW-1:0]       pmax_x;
  logic [SW-1:0]       run_end;
  pta_plan_t           p_plan;
  logic [STAT_W-1:0]   p_status;
  logic [ADDR_W-1:0]   p_base;
  logic [SW-1:0]       p_sstart;
  logic [SW-1:0]       p_send;
  logic                p_ff;
  logic [SW-1:0]       p_wstart;
  logic [SW-1:0]       p_wend;
  logic [TYPE_W-1:0]   p_wtype;

  // scan compare
  logic [TYPE_W-1:0]   rd_data;
  logic                rd_en;
  logic                wr_en;
  logic                hit_free;
  logic                scan_end;
  logic                lim_fail;
  logic                found;
  logic                fail;
  logic [SW-1:0]       first_idx;

  assign page    = addr_r[ADDR_W-1:PAGE_SHIFT];
  assign page_x  = SW'(page);
  assign n_x     = SW'(scan_len);
  assign cnt_x   = SW'(cnt_r);
  assign pmax_x  = SW'(PAGE_COUNT);
  assign run_end = page_x + cnt_x;

  always_comb begin
    p_plan   = PLAN_DONE;
    p_status = STAT_INVALID;
    p_base   = '0;
    p_sstart = '0;
    p_send   = n_x;
    p_ff     = 1'b1;
    p_wstart = page_x;
    p_wend   = run_end;
    p_wtype  = mt_r;
    if (op_r > OP_LOAD) begin
      p_status = STAT_INVALID;
    end else if (op_r != OP_ALLOC_ANY && addr_r[PAGE_SHIFT-1:0] != '0) begin
      p_status = STAT_INVALID;
    end else if (op_r <= OP_ALLOC_AT && mt_r >= TYPE_RSVD_MIN) begin
      p_status = STAT_INVALID;
    end else if (op_r <= OP_FREE && cnt_r == '0) begin
      p_status = STAT_INVALID;
    end else if (op_r == OP_ALLOC_ANY || op_r == OP_ALLOC_BELOW) begin
      p_plan   = PLAN_SCAN;
      p_status = STAT_OK;
    end else if (op_r == OP_ALLOC_AT) begin
      if (addr_r > top_of_memory) begin
        p_status = STAT_NOT_FOUND;
      end else if (page_x >= n_x || cnt_x > n_x - page_x) begin
        p_status = STAT_NO_RES;
      end else begin
        // every page of the fixed run must be free
        p_plan   = PLAN_SCAN;
        p_status = STAT_OK;
        p_base   = addr_r;
        p_ff     = 1'b0;
        p_sstart = page_x;
        p_send   = run_end;
      end
    end else if (op_r == OP_FREE) begin
      if (addr_r > top_of_memory) begin
        p_status = STAT_INVALID;
      end else if (page_x >= n_x) begin
        p_status = STAT_NOT_FOUND;
      end else begin
        p_plan   = PLAN_WRITE;
        p_status = STAT_OK;
        p_base   = addr_r;
        p_wend   = (run_end < n_x) ? run_end : n_x;
        p_wtype  = TYPE_FREE;
      end
    end else begin
      if (page_x >= pmax_x) begin
        p_status = STAT_INVALID;
      end else begin
        p_plan   = PLAN_WRITE;
        p_status = STAT_OK;
        p_base   = addr_r;
        p_wend   = page_x + SW'(1);
      end
    end
  end

  // read data lines up with vld_r/chk_r in the cycle after issue
  assign rd_en     = cmd.scan_step && (iss_r < send_r);
  assign hit_free  = vld_r && (rd_data == TYPE_FREE);
  assign scan_end  = !vld_r && (iss_r >= send_r);
  assign first_idx = (run_r == '0) ? chk_r : start_r;

  always_comb begin
    lim_fail = 1'b0;
    if (ff_r) begin
      lim_fail = vld_r && lim_r && (chk_r > page_x);
      found    = !lim_fail && hit_free && (run_r + CNT_IN_W'(1) == cnt_r);
      fail     = lim_fail || scan_end;
    end else begin
      found = scan_end;
      fail  = vld_r && (rd_data != TYPE_FREE);
    end
  end

  assign wr_en = cmd.write_step && (wp_r < wend_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.plan_apply) begin
        vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        vld_r <= rd_en;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_opcode;
      addr_r <= in_address;
      cnt_r  <= in_page_count;
      mt_r   <= in_mem_type;
    end
    if (cmd.plan_apply) begin
      res_status_r <= p_status;
      res_base_r   <= p_base;
      iss_r        <= p_sstart;
      send_r       <= p_send;
      ff_r         <= p_ff;
      lim_r        <= (op_r == OP_ALLOC_BELOW);
      run_r        <= '0;
      wp_r         <= p_wstart;
      wend_r       <= p_wend;
      wtype_r      <= p_wtype;
    end
    if (cmd.scan_step) begin
      chk_r <= iss_r;
      if (rd_en) begin
        iss_r <= iss_r + SW'(1);
      end
      if (hit_free) begin
        if (run_r == '0) begin
          start_r <= chk_r;
        end
        run_r <= run_r + CNT_IN_W'(1);
      end else if (vld_r) begin
        run_r <= '0;
      end
      if (found && ff_r) begin
        res_base_r <= {first_idx[PAGE_W-1:0], {PAGE_SHIFT{1'b0}}};
        wp_r       <= first_idx;
        wend_r     <= first_idx + cnt_x;
      end else if (fail) begin
        res_status_r <= STAT_NO_RES;
        res_base_r   <= '0;
      end
    end
    if (wr_en) begin
      wp_r <= wp_r + SW'(1);
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_base_r   <= res_base_r;
    end
  end

  pta_ram #(
    .WIDTH(TYPE_W),
    .DEPTH(PAGE_COUNT)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wp_r[PIDX_W-1:0]),
    .wr_data(wtype_r),
    .rd_en  (rd_en),
    .rd_addr(iss_r[PIDX_W-1:0]),
    .rd_data(rd_data)
  );

  assign stat.plan       = p_plan;
  assign stat.scan_found = found;
  assign stat.scan_fail  = fail;
  assign stat.write_busy = wp_r < wend_r;
  assign stat.out_full   = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_base_address = out_base_r;

endmodule

>>> rtl/pta_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pta_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pta_pkg::STAT_W-1:0]    out_status,
  input logic [pta_pkg::ADDR_W-1:0]    out_base_address,
  input logic                          pready
);

  import pta_pkg::*;

  // a waiting word holds until taken
  `PTA_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_base_address), "output word changed while stalled")

  // failures report a zero base
  `PTA_ASSERT(a_fail_zero, clk, rst_n, out_valid && out_status != STAT_OK |-> out_base_address == '0, "nonzero base on failure")

  // bases are page aligned
  `PTA_ASSERT(a_base_align, clk, rst_n, out_valid |-> out_base_address[PAGE_SHIFT-1:0] == '0, "base not page aligned")

  // a request is in work right after it is taken
  `PTA_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall |=> in_stall, "second request taken while busy")

  `PTA_ASSERT_ALWAYS(a_pready, clk, pready, "config port not ready")

endmodule

bind page_type_map_allocator pta_checker u_pta_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_base_address(out_base_address),
  .pready          (pready)
);

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import pta_pkg::*;

  localparam int MAP_DEPTH   = PAGE_COUNT_DEF;
  localparam int LIMIT       = 4_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_ROWS    = 25;
  localparam int NUM_PHASES  = 5;

  // opcodes past OP_LOAD are rejected
  localparam logic [OP_W-1:0] OP_BAD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;
  localparam logic [TYPE_W-1:0] TYPE_RSVD_MAX = 4'd15;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] base;
  } alloc_result_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [ADDR_W-1:0]   addr;
    logic [CNT_IN_W-1:0] cnt;
    logic [TYPE_W-1:0]   mt;
    bit                  typed;
    logic [STAT_W-1:0]   status;
    logic [ADDR_W-1:0]   base;
  } alloc_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_opcode = '0;
  logic [ADDR_W-1:0]   in_address = '0;
  logic [CNT_IN_W-1:0] in_page_count = '0;
  logic [TYPE_W-1:0]   in_mem_type = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [ADDR_W-1:0]   out_base_address;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  page_type_map_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_address       (in_address),
    .in_page_count    (in_page_count),
    .in_mem_type      (in_mem_type),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_base_address (out_base_address),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // shadow of the page map and registers
  logic [TYPE_W-1:0] page_map [MAP_DEPTH];
  logic [ADDR_W-1:0] map_top = TOP_RESET;
  logic [PIN_W-1:0]  map_span = PIN_RESET;

  alloc_result_t pending_results [$];
  int            miss_count = 0;
  int            cycle_count = 0;
  int            tx_idle_pct = 38;
  int            rx_idle_pct = 70;
  bit            want_hold = 1'b0;
  bit            hold_done = 1'b0;

  alloc_req_t dir_rows [NUM_ROWS];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned scan_span();
    return (map_span < MAP_DEPTH) ? longint'(map_span) : longint'(MAP_DEPTH);
  endfunction

  function automatic alloc_result_t predict_alloc(alloc_req_t q);
    alloc_result_t    r;
    longint unsigned  n, pg, first, run, i, addr64;
    bit               found;
    r.status = STAT_OK;
    r.base   = '0;
    n        = scan_span();
    addr64   = longint'(q.addr);
    pg       = addr64 >> PAGE_SHIFT;
    if (q.op > OP_LOAD) begin
      r.status = STAT_INVALID;
    end else if (q.op != OP_ALLOC_ANY && q.addr[PAGE_SHIFT-1:0] != '0) begin
      r.status = STAT_INVALID;
    end else if (q.op <= OP_ALLOC_AT && q.mt >= TYPE_RSVD_MIN) begin
      r.status = STAT_INVALID;
    end else if (q.op <= OP_FREE && q.cnt == '0) begin
      r.status = STAT_INVALID;
    end else if (q.op == OP_ALLOC_ANY || q.op == OP_ALLOC_BELOW) begin
      found = 1'b0;
      run   = 0;
      first = 0;
      for (i = 0; i < n && !found; i++) begin
        // limited search gives up at the first page past the limit
        if (q.op == OP_ALLOC_BELOW && i * PAGE_BYTES > addr64) break;
        if (page_map[i] == TYPE_FREE) begin
          if (run == 0) first = i;
          run++;
          if (run == q.cnt) found = 1'b1;
        end else begin
          run = 0;
        end
      end
      if (found) begin
        for (i = 0; i < q.cnt; i++) page_map[first + i] = q.mt;
        r.base = ADDR_W'(first * PAGE_BYTES);
      end else begin
        r.status = STAT_NO_RES;
      end
    end else if (q.op == OP_ALLOC_AT) begin
      if (q.addr > map_top) begin
        r.status = STAT_NOT_FOUND;
      end else if (pg >= n || q.cnt > n - pg) begin
        r.status = STAT_NO_RES;
      end else begin
        found = 1'b1;
        for (i = 0; i < q.cnt; i++)
          if (page_map[pg + i] != TYPE_FREE) found = 1'b0;
        if (found) begin
          for (i = 0; i < q.cnt; i++) page_map[pg + i] = q.mt;
          r.base = q.addr;
        end else begin
          r.status = STAT_NO_RES;
        end
      end
    end else if (q.op == OP_FREE) begin
      if (q.addr > map_top) begin
        r.status = STAT_INVALID;
      end else if (pg >= n) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        // clipped at the end of the scanned map
        for (i = 0; i < q.cnt && pg + i < n; i++) page_map[pg + i] = TYPE_FREE;
        r.base = q.addr;
      end
    end else begin
      if (pg >= MAP_DEPTH) begin
        r.status = STAT_INVALID;
      end else begin
        page_map[pg] = q.mt;
        r.base = q.addr;
      end
    end
    if (r.status != STAT_OK) r.base = '0;
    return r;
  endfunction

  function automatic alloc_req_t random_request(longint unsigned span);
    alloc_req_t q;
    int unsigned sel;
    longint unsigned pg;
    q = '0;
    sel = $urandom_range(99, 0);
    if (sel < 25)      q.op = OP_ALLOC_ANY;
    else if (sel < 40) q.op = OP_ALLOC_BELOW;
    else if (sel < 58) q.op = OP_ALLOC_AT;
    else if (sel < 78) q.op = OP_FREE;
    else if (sel < 88) q.op = OP_LOAD;
    else               q.op = OP_W'($urandom_range(OP_BAD_HI, OP_BAD_LO));

    sel = $urandom_range(99, 0);
    if (sel < 70) begin
      pg = $urandom_range(int'(span) + 3, 0);
      q.addr = ADDR_W'(pg << PAGE_SHIFT);
    end else if (sel < 85) begin
      q.addr = $urandom();
    end else begin
      q.addr = $urandom() & ~ADDR_W'(PAGE_BYTES - 1);
    end

    sel = $urandom_range(99, 0);
    if (sel < 60)      q.cnt = CNT_IN_W'($urandom_range(6, 1));
    else if (sel < 75) q.cnt = CNT_IN_W'($urandom_range(int'(span) + 2, 1));
    else if (sel < 85) q.cnt = '0;
    else               q.cnt = CNT_IN_W'($urandom());

    if ($urandom_range(99, 0) < 80) q.mt = TYPE_W'($urandom_range(13, 0));
    else                            q.mt = TYPE_W'($urandom());
    return q;
  endfunction

  // drive one request word, wait for it to be taken, log its expected result
  task automatic send_request(alloc_req_t q);
    alloc_result_t want;
    while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= q.op;
    in_address    <= q.addr;
    in_page_count <= q.cnt;
    in_mem_type   <= q.mt;
    do @(posedge clk); while (in_stall !== 1'b0);
    want = predict_alloc(q);
    if (q.typed) begin
      want.status = q.status;
      want.base   = q.base;
    end
    pending_results.push_back(want);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TOP) map_top = data;
    else                map_span = data[PIN_W-1:0];
  endtask

  task automatic drain(input int extra);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic void log_miss(string what, alloc_result_t want, alloc_result_t got);
    miss_count++;
    if (miss_count <= 10)
      $display("%0t: %s: status exp %0d got %0d, base exp %h got %h",
               $realtime, what, want.status, got.status, want.base, got.base);
  endfunction

  always @(posedge clk) begin : result_check
    alloc_result_t want, got;
    got.status = out_status;
    got.base   = out_base_address;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        log_miss("unexpected result word", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.base !== want.base)
          log_miss("result mismatch", want, got);
      end
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (want_hold && !hold_done) begin
        // long hold-off so the block backs up into its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= (rx_idle_pct != 0) && ($urandom_range(99, 0) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] ph_top  [NUM_PHASES];
    logic [31:0] ph_span [NUM_PHASES];
    int          ph_tx   [NUM_PHASES];
    int          ph_rx   [NUM_PHASES];
    int          ph_n    [NUM_PHASES];
    int          p, k;

    for (k = 0; k < MAP_DEPTH; k++) page_map[k] = '0;

    // op, addr, count, type, typed, status, base
    dir_rows = '{
      '{OP_BAD_LO, 32'h0000_0000, 17'd1, 4'd0, 1'b1, STAT_INVALID, 32'h0},
      '{OP_BAD_HI, 32'hFFFF_FFFF, 17'h1_FFFF, 4'hF, 1'b1, STAT_INVALID, 32'h0},
      '{OP_ALLOC_BELOW, 32'h0000_0001, 17'd1, 4'd0, 1'b1, STAT_INVALID, 32'h0},
      '{OP_LOAD, 32'hFFFF_FFFF, 17'd1, 4'd0, 1'b1, STAT_INVALID, 32'h0},
      '{OP_ALLOC_ANY, 32'hFFFF_FFFF, 17'd1, TYPE_RSVD_MIN, 1'b1, STAT_INVALID, 32'h0},
      '{OP_ALLOC_AT, 32'h0000_0000, 17'd1, TYPE_RSVD_MAX, 1'b1, STAT_INVALID, 32'h0},
      '{OP_FREE, 32'h0000_0000, 17'd0, 4'd0, 1'b1, STAT_INVALID, 32'h0},
      '{OP_ALLOC_ANY, 32'h0000_0000, 17'd0, 4'd0, 1'b1, STAT_INVALID, 32'h0},
      '{OP_LOAD, 32'hFFFF_F000, 17'd1, 4'd3, 1'b1, STAT_INVALID, 32'h0},
      '{OP_FREE, 32'hFFFF_F000, 17'd1, 4'd0, 1'b1, STAT_INVALID, 32'h0},
      '{OP_ALLOC_AT, 32'hFFFF_F000, 17'd1, 4'd0, 1'b1, STAT_NOT_FOUND, 32'h0},
      '{OP_FREE, 32'h1000_0000, 17'd1, 4'd0, 1'b1, STAT_NOT_FOUND, 32'h0},
      '{OP_LOAD, 32'h0000_0000, 17'd0, TYPE_RSVD_MAX, 1'b1, STAT_OK, 32'h0},
      '{OP_LOAD, 32'h0FFF_F000, 17'd0, TYPE_FREE, 1'b1, STAT_OK, 32'h0FFF_F000},
      // frees the whole map, so no later scan meets an unloaded entry
      '{OP_FREE, 32'h0000_0000, 17'h1_0000, 4'd0, 1'b1, STAT_OK, 32'h0},
      '{OP_ALLOC_ANY, 32'hFFFF_FFFF, 17'd1, 4'd0, 1'b1, STAT_OK, 32'h0},
      '{OP_ALLOC_BELOW, 32'h0000_0000, 17'd1, 4'd0, 1'b1, STAT_NO_RES, 32'h0},
      '{OP_ALLOC_BELOW, 32'hFFFF_F000, 17'h1_0000, 4'd0, 1'b1, STAT_NO_RES, 32'h0},
      '{OP_ALLOC_AT, 32'h0000_1000, 17'd2, 4'd13, 1'b0, STAT_OK, 32'h0},
      '{OP_ALLOC_AT, 32'h0000_2000, 17'd1, 4'd0, 1'b1, STAT_NO_RES, 32'h0},
      '{OP_ALLOC_AT, 32'h0FFF_F000, 17'd2, 4'd0, 1'b1, STAT_NO_RES, 32'h0},
      '{OP_ALLOC_ANY, 32'h0000_0000, 17'h1_0000, 4'd0, 1'b1, STAT_NO_RES, 32'h0},
      '{OP_FREE, 32'h0000_1000, 17'h1_FFFF, 4'd0, 1'b1, STAT_OK, 32'h0000_1000},
      '{OP_ALLOC_ANY, 32'h0000_0000, 17'd3, 4'd5, 1'b0, STAT_OK, 32'h0},
      '{OP_ALLOC_BELOW, 32'h0000_4000, 17'd1, 4'd9, 1'b0, STAT_OK, 32'h0}
    };

    ph_top  = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0002_0000, 32'h0004_0000, 32'h0FFF_F000};
    ph_span = '{32'd1, 32'd37, 32'd48, 32'd64, 32'h0001_FFFF};
    ph_tx   = '{38, 38, 70, 0, 0};
    ph_rx   = '{70, 70, 38, 0, 0};
    ph_n    = '{10, 15, 25, 20, 5};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < NUM_ROWS; k++) send_request(dir_rows[k]);
    in_valid <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      drain(8);
      cfg_write(REG_TOP, ph_top[p]);
      cfg_write(REG_PIN, ph_span[p]);
      tx_idle_pct = ph_tx[p];
      rx_idle_pct = ph_rx[p];
      if (p == 3) want_hold = 1'b1;
      for (k = 0; k < ph_n[p]; k++) send_request(random_request(scan_span()));
      in_valid <= 1'b0;
    end

    drain(16);
    if (miss_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
